### src/sstf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_pkg: shared types and constants for the SSTF disk scheduler
// Holds the request/result payload structs, the controller command and
// datapath status bundles and the fixed field widths.
// ----------------------------------------------------------------------------
package sstf_pkg;

  // Fixed field widths
  localparam int TRACK_BITS = 16;
  localparam int SEEK_W     = 21;
  localparam int HEAD_W     = 16;

  // Default batch capacity
  localparam int DEF_MAX_REQUESTS = 32;

  // Saturation limit of the running seek total
  localparam logic [SEEK_W-1:0] SEEK_MAX = {SEEK_W{1'b1}};

  // Register map (register index, byte address bit 2)
  localparam logic REG_START_HEAD = 1'b0;

  typedef struct packed {
    logic [TRACK_BITS-1:0] request_track;
    logic                  last_request;
  } sstf_req_t;

  typedef struct packed {
    logic [TRACK_BITS-1:0] served_track;
    logic [TRACK_BITS-1:0] move_distance;
    logic [SEEK_W-1:0]     total_seek;
    logic                  batch_overflow;
    logic                  last_served;
  } sstf_result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;         // store one request
    logic begin_batch;  // clear served map, reload head, zero seek total
    logic scan_issue;   // read the entry at the scan index and advance
    logic pick_commit;  // emit best pick, mark it served
  } sstf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;    // scan index points at the last loaded entry
    logic pick_last;    // current pick is the final one of the batch
  } sstf_status_t;

endpackage

### src/sstf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_ctrl: sequencing state machine of the SSTF scheduler
// Loads requests while idle, then runs one scan pass over the loaded
// entries per pick and commits the nearest unserved entry.
// ----------------------------------------------------------------------------
module sstf_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   last_request,
  input  sstf_pkg::sstf_status_t status,
  output sstf_pkg::sstf_cmd_t    cmd,
  output logic                   busy
);
  import sstf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_request) begin
            cmd.begin_batch = 1'b1;
            state_next      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      // last read result is compared in this cycle
      ST_DRAIN: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.pick_commit = 1'b1;
        state_next      = status.pick_last ? ST_IDLE : ST_SCAN;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

### src/sstf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_datapath: request store, nearest-track search and seek accounting
// Request memory with a registered read port, served map, best-candidate
// tracking over one scan pass, and the registered result transaction.
// ----------------------------------------------------------------------------
module sstf_datapath #(
  parameter int MAX_REQUESTS = sstf_pkg::DEF_MAX_REQUESTS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sstf_pkg::sstf_cmd_t               cmd,
  input  logic [sstf_pkg::TRACK_BITS-1:0]   request_track,
  input  logic [sstf_pkg::HEAD_W-1:0]       start_head,
  output sstf_pkg::sstf_status_t            status,
  output logic                              result_valid,
  output sstf_pkg::sstf_result_t            result
);
  import sstf_pkg::*;

  localparam int IDX_W = $clog2(MAX_REQUESTS);
  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

  // Request memory
  logic [TRACK_BITS-1:0]   mem [MAX_REQUESTS];
  logic [TRACK_BITS-1:0]   rd_data;
  logic [IDX_W-1:0]        rd_idx;
  logic                    rd_vld;

  // Batch state
  logic [CNT_W-1:0]        loaded_count;
  logic                    dropped;
  logic [MAX_REQUESTS-1:0] served;
  logic [TRACK_BITS-1:0]   head;
  logic [SEEK_W-1:0]       seek_total;
  logic [IDX_W-1:0]        scan_idx;
  logic [CNT_W-1:0]        pick_cnt;

  // Best candidate of the current pass
  logic                    best_found;
  logic [IDX_W-1:0]        best_idx;
  logic [TRACK_BITS-1:0]   best_dist;
  logic [TRACK_BITS-1:0]   best_track;

  logic                    not_full;
  logic [TRACK_BITS-1:0]   cand_dist;
  logic                    cand_take;
  logic [SEEK_W:0]         seek_sum;
  logic [SEEK_W-1:0]       seek_next;

  assign not_full = (loaded_count < CNT_W'(MAX_REQUESTS));

  // Memory write on load, registered read during the scan
  always_ff @(posedge clk) begin
    if (cmd.load && not_full) begin
      mem[loaded_count[IDX_W-1:0]] <= request_track;
    end
    if (cmd.scan_issue) begin
      rd_data <= mem[scan_idx];
    end
  end

  // Candidate distance and compare (earliest index wins ties)
  assign cand_dist = (head >= rd_data) ? (head - rd_data) : (rd_data - head);
  assign cand_take = rd_vld && !served[rd_idx] && (!best_found || (cand_dist < best_dist));

  // Saturating seek accumulation
  assign seek_sum  = {1'b0, seek_total} + (SEEK_W + 1)'(best_dist);
  assign seek_next = seek_sum[SEEK_W] ? SEEK_MAX : seek_sum[SEEK_W-1:0];

  // Status to the controller
  assign status.scan_last = (CNT_W'(scan_idx) == (loaded_count - CNT_W'(1)));
  assign status.pick_last = ((pick_cnt + CNT_W'(1)) == loaded_count);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
      dropped      <= 1'b0;
      served       <= '0;
      head         <= '0;
      seek_total   <= '0;
      scan_idx     <= '0;
      pick_cnt     <= '0;
      rd_vld       <= 1'b0;
      best_found   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rd_vld       <= cmd.scan_issue;
      result_valid <= cmd.pick_commit;

      // request load
      if (cmd.load) begin
        if (not_full) begin
          loaded_count <= loaded_count + CNT_W'(1);
        end else begin
          dropped <= 1'b1;
        end
      end

      // batch start
      if (cmd.begin_batch) begin
        served     <= '0;
        head       <= TRACK_BITS'(start_head);
        seek_total <= '0;
        scan_idx   <= '0;
        pick_cnt   <= '0;
        best_found <= 1'b0;
      end

      // scan pass
      if (cmd.scan_issue) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (cand_take) begin
        best_found <= 1'b1;
      end

      // commit the pick
      if (cmd.pick_commit) begin
        served[best_idx] <= 1'b1;
        head             <= best_track;
        seek_total       <= seek_next;
        pick_cnt         <= pick_cnt + CNT_W'(1);
        scan_idx         <= '0;
        best_found       <= 1'b0;
        if (status.pick_last) begin
          loaded_count <= '0;
          dropped      <= 1'b0;
        end
      end
    end
  end

  // Best candidate payload
  always_ff @(posedge clk) begin
    if (cand_take) begin
      best_idx   <= rd_idx;
      best_dist  <= cand_dist;
      best_track <= rd_data;
    end
    if (cmd.scan_issue) begin
      rd_idx <= scan_idx;
    end
  end

  // Result transaction register
  always_ff @(posedge clk) begin
    if (cmd.pick_commit) begin
      result.served_track   <= best_track;
      result.move_distance  <= best_dist;
      result.total_seek     <= seek_next;
      result.batch_overflow <= dropped;
      result.last_served    <= status.pick_last;
    end
  end

endmodule

### src/sstf_disk_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstf_disk_scheduler_core: shortest-seek-time-first disk request scheduler
// Collects a batch of track requests and serves them nearest-first.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req when start is high and busy is low, one per cycle
//   while loading. The transaction with last_request set closes the batch and
//   starts service; requests past MAX_REQUESTS are dropped and reported by
//   batch_overflow on every result of that batch.
//   Service starts at the start_head register (APB, byte address 0). Each
//   pick reads every loaded entry once through the single memory read port,
//   then compares the last read entry and commits the nearest one. busy
//   stays high for the whole service.
//   Each result is shown for one cycle with result_valid high; the receiver
//   cannot stall, and last_served marks the final result of the batch.
//   Ties in distance go to the earliest loaded request; total_seek saturates.
//   Synchronous reset empties the batch and sets start_head to zero; no
//   memory clearing pass is needed.
// ----------------------------------------------------------------------------
module sstf_disk_scheduler_core #(
  parameter int MAX_REQUESTS = sstf_pkg::DEF_MAX_REQUESTS
) (
  input  logic                   clk,
  input  logic                   rst,
  // request channel
  input  logic                   start,
  output logic                   busy,
  input  sstf_pkg::sstf_req_t    req,
  // result channel
  output logic                   result_valid,
  output sstf_pkg::sstf_result_t result,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import sstf_pkg::*;

  logic [HEAD_W-1:0] start_head;
  sstf_cmd_t         cmd;
  sstf_status_t      status;
  logic              cfg_wr;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_head <= '0;
    end else if (cfg_wr && (paddr[2] == REG_START_HEAD)) begin
      start_head <= pwdata[HEAD_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_START_HEAD) begin
      prdata = 32'(start_head);
    end
  end

  // Controller
  sstf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .last_request (req.last_request),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy)
  );

  // Datapath
  sstf_datapath #(
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .request_track (req.request_track),
    .start_head    (start_head),
    .status        (status),
    .result_valid  (result_valid),
    .result        (result)
  );

endmodule
